### hdl/modbus_rtu_response_checker_unit_defines.svh
// Assertion macros used by the checker file of this block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef MODBUS_RTU_RESPONSE_CHECKER_UNIT_DEFINES_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_UNIT_DEFINES_SVH

// Property checked only outside of reset.
`define MRRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define MRRC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/mrrc_pkg.sv
`timescale 1ns / 1ps

package mrrc_pkg;

  // CRC16 as used on Modbus RTU links (reflected polynomial).
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Function codes of the accepted responses.
  localparam logic [7:0] FUNC_READ_INPUT  = 8'h04;
  localparam logic [7:0] FUNC_WRITE_MULTI = 8'h10;

  // Result status codes.
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_CRC_ADDR   = 2'd1;
  localparam logic [1:0] STATUS_FUNC_COUNT = 2'd2;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLAVE_ADDRESS  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESPONSE_KIND  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_REGISTER_COUNT = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0] SLAVE_ADDRESS_RESET  = 8'd1;
  localparam logic       RESPONSE_KIND_RESET  = 1'b0;
  localparam logic [3:0] REGISTER_COUNT_RESET = 4'd1;

endpackage

### hdl/mrrc_ifs.sv
`timescale 1ns / 1ps

// Received byte channel.
interface mrrc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       frame_start;

  modport source (output valid, output byte_value, output frame_start, input ready);
  modport sink (input valid, input byte_value, input frame_start, output ready);
endinterface

// Result channel, one register word or one status-only result per transfer.
interface mrrc_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] reg_word;
  logic [2:0]  reg_index;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, output reg_word, output reg_index, output status,
                  output last, input ready);
  modport sink (input valid, input reg_word, input reg_index, input status,
                input last, output ready);
endinterface

// Configuration write channel.
interface mrrc_cfg_if;
  import mrrc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [7:0]             data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/modbus_rtu_response_checker_unit.sv
// Intake: each byte from the third of a frame on starts the bit-serial CRC shifter, and no new
// byte is taken until the shifter is done; the first two bytes of a frame do not start it.
// Results: after the last byte of a frame the CRC shift ends and the check state gives the verdict;
// a register word is then read from the store (fetch, load) before it is sent, and
// each further word is fetched and loaded again after the previous result transfer.
// Reset: synchronous; clears control state, loads default configuration; word store is not cleared.
`timescale 1ns / 1ps

module modbus_rtu_response_checker_unit #(
  parameter int MAX_REGS = 8
) (
  input  logic          clk,
  input  logic          rst,
  mrrc_rx_if.sink       rx,
  mrrc_result_if.source result,
  mrrc_cfg_if.sink      cfg
);
  import mrrc_pkg::*;

  // The register count field is 4 bits, so at most 15 words can ever be stored.
  localparam int EFF_MAX = (MAX_REGS < 15) ? MAX_REGS : 15;
  localparam int LEN_MAX = (5 + 2 * EFF_MAX > 8) ? 5 + 2 * EFF_MAX : 8;
  localparam int POS_W   = $clog2(LEN_MAX);
  localparam int IDX_W   = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CRC,
    S_CHECK,
    S_FETCH,
    S_LOAD,
    S_SEND
  } state_t;

  // Configuration registers.
  logic [7:0] slave_address;
  logic       response_kind;
  logic [3:0] register_count;

  // Receiver state.
  state_t           state;
  logic [15:0]      crc;
  logic [7:0]       crc_shift;
  logic [2:0]       bit_cnt;
  logic [POS_W-1:0] byte_position;
  logic [7:0]       tb0;
  logic [7:0]       tb1;
  logic [7:0]       hdr0;
  logic [7:0]       hdr1;
  logic [7:0]       hdr2;
  logic             frame_done;
  logic [IDX_W-1:0] word_idx;

  // Output register.
  logic        out_valid;
  logic [15:0] out_word;
  logic [2:0]  out_index;
  logic [1:0]  out_status;
  logic        out_last;

  // Word store, high and low bytes kept apart so each byte is a plain write.
  logic [7:0] mem_hi [EFF_MAX];
  logic [7:0] mem_lo [EFF_MAX];
  logic [7:0] rd_hi;
  logic [7:0] rd_lo;

  logic             accept;
  logic [3:0]       eff_count;
  logic [7:0]       count_bytes;
  logic [7:0]       frame_len;
  logic [POS_W-1:0] cur_pos;
  logic [7:0]       cur_tb0;
  logic [7:0]       cur_tb1;
  logic [15:0]      cur_crc;
  logic [7:0]       pos_ext;
  logic [7:0]       pos_next_ext;
  logic             is_last;
  logic             feed;
  logic [POS_W-1:0] off;
  logic [POS_W-2:0] word_slot;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;
  logic             wr_hi_en;
  logic [7:0]       lo_data;
  logic             crc_bit;
  logic [15:0]      crc_step;
  logic [1:0]       chk_status;
  logic             chk_single;
  logic             word_last;

  assign accept    = rx.valid && rx.ready;
  assign rx.ready  = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign result.valid     = out_valid;
  assign result.reg_word  = out_word;
  assign result.reg_index = out_index;
  assign result.status    = out_status;
  assign result.last      = out_last;

  // Frame geometry from the current configuration.
  always_comb begin
    eff_count   = (32'(register_count) > EFF_MAX) ? 4'(EFF_MAX) : register_count;
    count_bytes = {3'b000, eff_count, 1'b0};
    frame_len   = response_kind ? 8'd8 : 8'd5 + count_bytes;
  end

  // Byte intake: a frame start restarts position, CRC and the trailing byte pair.
  always_comb begin
    cur_pos      = rx.frame_start ? '0 : byte_position;
    cur_tb0      = rx.frame_start ? 8'h00 : tb0;
    cur_tb1      = rx.frame_start ? 8'h00 : tb1;
    cur_crc      = rx.frame_start ? CRC_INIT : crc;
    pos_ext      = 8'(cur_pos);
    pos_next_ext = pos_ext + 8'd1;
    is_last      = (pos_next_ext >= frame_len);
    feed         = (pos_ext >= 8'd2);
    off          = cur_pos - POS_W'(3);
    word_slot    = off[POS_W-1:1];
    wr_addr      = word_slot[IDX_W-1:0];
    wr_en        = accept && !response_kind && (pos_ext >= 8'd3) && (8'(off) < count_bytes);
    wr_hi_en     = wr_en && !off[0];
    lo_data      = off[0] ? rx.byte_value : 8'h00;
  end

  // One bit of the reflected CRC per cycle.
  always_comb begin
    crc_bit  = crc[0] ^ crc_shift[0];
    crc_step = {1'b0, crc[15:1]} ^ (crc_bit ? CRC_POLY : 16'h0000);
  end

  // Frame verdict: CRC and address first, then function code and, for read responses, byte count.
  always_comb begin
    chk_status = STATUS_OK;
    chk_single = 1'b1;
    if (({tb1, tb0} != crc) || (hdr0 != slave_address)) begin
      chk_status = STATUS_CRC_ADDR;
    end else if (response_kind) begin
      chk_status = (hdr1 != FUNC_WRITE_MULTI) ? STATUS_FUNC_COUNT : STATUS_OK;
    end else if ((hdr1 != FUNC_READ_INPUT) || (hdr2 != count_bytes)) begin
      chk_status = STATUS_FUNC_COUNT;
    end else if (eff_count != 4'd0) begin
      chk_single = 1'b0;
    end
  end

  assign word_last = ((5'(word_idx) + 5'd1) == 5'(eff_count));

  // Word store: written during intake, read one word at a time while emitting.
  always_ff @(posedge clk) begin
    if (wr_hi_en) begin
      mem_hi[wr_addr] <= rx.byte_value;
    end
    if (wr_en) begin
      mem_lo[wr_addr] <= lo_data;
    end
    rd_hi <= mem_hi[word_idx];
    rd_lo <= mem_lo[word_idx];
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address  <= SLAVE_ADDRESS_RESET;
      response_kind  <= RESPONSE_KIND_RESET;
      register_count <= REGISTER_COUNT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_SLAVE_ADDRESS:  slave_address  <= cfg.data;
        CFG_RESPONSE_KIND:  response_kind  <= cfg.data[0];
        CFG_REGISTER_COUNT: register_count <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  // Sequencer: intake, bit-serial CRC, check, then word emission.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      crc           <= CRC_INIT;
      crc_shift     <= 8'h00;
      bit_cnt       <= 3'd0;
      byte_position <= '0;
      tb0           <= 8'h00;
      tb1           <= 8'h00;
      hdr0          <= 8'h00;
      hdr1          <= 8'h00;
      hdr2          <= 8'h00;
      frame_done    <= 1'b0;
      word_idx      <= '0;
      out_valid     <= 1'b0;
      out_word      <= 16'h0000;
      out_index     <= 3'd0;
      out_status    <= STATUS_OK;
      out_last      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            tb0        <= cur_tb1;
            tb1        <= rx.byte_value;
            crc        <= cur_crc;
            crc_shift  <= cur_tb0;
            bit_cnt    <= 3'd0;
            frame_done <= is_last;
            if (pos_ext == 8'd0) begin
              hdr0 <= rx.byte_value;
            end
            if (pos_ext == 8'd1) begin
              hdr1 <= rx.byte_value;
            end
            if (pos_ext == 8'd2) begin
              hdr2 <= rx.byte_value;
            end
            byte_position <= is_last ? '0 : POS_W'(pos_next_ext);
            state         <= feed ? S_CRC : S_IDLE;
          end
        end
        S_CRC: begin
          crc       <= crc_step;
          crc_shift <= {1'b0, crc_shift[7:1]};
          bit_cnt   <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            state <= frame_done ? S_CHECK : S_IDLE;
          end
        end
        S_CHECK: begin
          crc      <= CRC_INIT;
          word_idx <= '0;
          if (chk_single) begin
            out_valid  <= 1'b1;
            out_word   <= 16'h0000;
            out_index  <= 3'd0;
            out_status <= chk_status;
            out_last   <= 1'b1;
            state      <= S_SEND;
          end else begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          out_valid  <= 1'b1;
          out_word   <= {rd_hi, rd_lo};
          out_index  <= 3'(word_idx);
          out_status <= STATUS_OK;
          out_last   <= word_last;
          state      <= S_SEND;
        end
        S_SEND: begin
          if (result.ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              state <= S_IDLE;
            end else begin
              word_idx <= IDX_W'(word_idx + 1'b1);
              state    <= S_FETCH;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/mrrc_checker.sv
`timescale 1ns / 1ps
`include "modbus_rtu_response_checker_unit_defines.svh"

module mrrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        rx_valid,
  input logic        rx_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [15:0] res_reg_word,
  input logic [2:0]  res_reg_index,
  input logic [1:0]  res_status,
  input logic        res_last
);
  import mrrc_pkg::*;

  // A stalled result keeps its payload.
  `MRRC_ASSERT(a_result_hold, res_valid && !res_ready |=> res_valid && $stable(res_reg_word) && $stable(res_reg_index) && $stable(res_status) && $stable(res_last), "result changed while stalled")

  // No byte is taken while a result waits for its transfer.
  `MRRC_ASSERT(a_no_overlap, !(rx_ready && res_valid), "byte intake open while a result is pending")

  // An error result is a single status-only result.
  `MRRC_ASSERT(a_status_only, res_valid && res_status != STATUS_OK |-> res_last && res_reg_word == 16'h0000 && res_reg_index == 3'd0, "error result carries data or is not last")

  // Reset leaves no result pending.
  `MRRC_ASSERT_RST(a_reset_clear, rst |=> !res_valid, "result valid after reset")

endmodule

bind modbus_rtu_response_checker_unit mrrc_checker u_mrrc_checker (
  .clk           (clk),
  .rst           (rst),
  .rx_valid      (rx.valid),
  .rx_ready      (rx.ready),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .res_reg_word  (result.reg_word),
  .res_reg_index (result.reg_index),
  .res_status    (result.status),
  .res_last      (result.last)
);
